// File: rtl/core/tpsd_pkg.sv
// Shared types and constants for the three-point space derivative block.
`timescale 1ns / 1ps
`default_nettype none

package tpsd_pkg;

  // Reciprocal register width (unsigned Q16.16)
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned RES_W   = 32;

  // Register file indexes
  typedef enum logic [IDX_W-1:0] {
    REG_INV_LEN_X    = 3'd0,
    REG_INV_LEN_Y    = 3'd1,
    REG_INV_LEN_Z    = 3'd2,
    REG_INV_LEN_SQ_X = 3'd3,
    REG_INV_LEN_SQ_Y = 3'd4,
    REG_INV_LEN_SQ_Z = 3'd5
  } tpsd_reg_t;

  // Axis codes; the unused code selects z
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Reset value of every reciprocal register (1.0)
  localparam logic [CFG_W-1:0] RECIP_ONE = 32'h0001_0000;

  // Pipeline load strobes handed to every lane
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } tpsd_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/tpsd_cfg.sv
// Reciprocal register file and per-axis reciprocal selection.
`timescale 1ns / 1ps
`default_nettype none

module tpsd_cfg
  import tpsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic [1:0]       axis,
  output logic      [CFG_W-1:0] k1,
  output logic      [CFG_W-1:0] k2
);

  logic [CFG_W-1:0] inv_len_x, inv_len_y, inv_len_z;
  logic [CFG_W-1:0] inv_len_sq_x, inv_len_sq_y, inv_len_sq_z;

  // Write one register per transaction; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_len_x    <= RECIP_ONE;
      inv_len_y    <= RECIP_ONE;
      inv_len_z    <= RECIP_ONE;
      inv_len_sq_x <= RECIP_ONE;
      inv_len_sq_y <= RECIP_ONE;
      inv_len_sq_z <= RECIP_ONE;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_INV_LEN_X:    inv_len_x    <= cfg_data;
        REG_INV_LEN_Y:    inv_len_y    <= cfg_data;
        REG_INV_LEN_Z:    inv_len_z    <= cfg_data;
        REG_INV_LEN_SQ_X: inv_len_sq_x <= cfg_data;
        REG_INV_LEN_SQ_Y: inv_len_sq_y <= cfg_data;
        REG_INV_LEN_SQ_Z: inv_len_sq_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the reciprocals for the item's axis; the spare code acts as z
  always_comb begin
    case (axis)
      AXIS_X: begin
        k1 = inv_len_x;
        k2 = inv_len_sq_x;
      end
      AXIS_Y: begin
        k1 = inv_len_y;
        k2 = inv_len_sq_y;
      end
      default: begin
        k1 = inv_len_z;
        k2 = inv_len_sq_z;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/tpsd_lane.sv
// One component lane: stencil differences, split multiply, round and saturate.
`timescale 1ns / 1ps
`default_nettype none

module tpsd_lane
  import tpsd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire tpsd_ctrl_t                     ctrl,
  input  wire logic                           prev_valid,
  input  wire logic                           next_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prev_s,
  input  wire logic signed [SAMPLE_WIDTH-1:0] cur_s,
  input  wire logic signed [SAMPLE_WIDTH-1:0] next_s,
  input  wire logic        [CFG_W-1:0]        k1,
  input  wire logic        [CFG_W-1:0]        k2,
  output logic signed      [RES_W-1:0]        first_d,
  output logic signed      [RES_W-1:0]        second_d
);

  localparam int DW = SAMPLE_WIDTH + 2;          // difference width
  localparam int PW = DW + 16;                   // partial product width
  localparam int FW = DW + 32;                   // full product width
  localparam int RW = (DW + 17 > 33) ? DW + 17 : 33;  // rounded width
  localparam logic [RW-1:0] POS_MAX = RW'(33'h0_7FFF_FFFF);
  localparam logic [RW-1:0] NEG_MAX = RW'(33'h0_8000_0000);

  // Stage 0: differences from the current transaction
  logic signed [DW-1:0] p_ext, c_ext, n_ext, d1, d2;
  logic [DW-1:0] mag1_next, mag2_next;

  always_comb begin
    p_ext = prev_valid ? DW'(prev_s) : '0;
    c_ext = DW'(cur_s);
    n_ext = next_valid ? DW'(next_s) : '0;
    if (!prev_valid) begin
      d1 = n_ext - c_ext;
    end else if (!next_valid) begin
      d1 = c_ext - p_ext;
    end else begin
      d1 = n_ext - p_ext;
    end
    d2 = n_ext - (c_ext <<< 1) + p_ext;
    mag1_next = d1[DW-1] ? DW'(-d1) : DW'(d1);
    mag2_next = d2[DW-1] ? DW'(-d2) : DW'(d2);
  end

  // Stage 1: hold magnitudes, signs and the form of the derivative
  logic [DW-1:0] mag1, mag2;
  logic          neg1_s1, neg2_s1, central_s1;

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      mag1       <= mag1_next;
      mag2       <= mag2_next;
      neg1_s1    <= d1[DW-1];
      neg2_s1    <= d2[DW-1];
      central_s1 <= prev_valid & next_valid;
    end
  end

  // Stage 2: 16-bit halves of the reciprocal times the magnitude
  logic [PW-1:0] pl1, ph1, pl2, ph2;
  logic          neg1_s2, neg2_s2, central_s2;

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      pl1        <= PW'(mag1) * PW'(k1[15:0]);
      ph1        <= PW'(mag1) * PW'(k1[31:16]);
      pl2        <= PW'(mag2) * PW'(k2[15:0]);
      ph2        <= PW'(mag2) * PW'(k2[31:16]);
      neg1_s2    <= neg1_s1;
      neg2_s2    <= neg2_s1;
      central_s2 <= central_s1;
    end
  end

  // Round half away from zero on the magnitude, then clamp and apply sign
  function automatic logic [RES_W-1:0] sat_sign(input logic [RW-1:0] r, input logic neg);
    logic [RW-1:0] c;
    begin
      if (neg) begin
        c = (r > NEG_MAX) ? NEG_MAX : r;
        sat_sign = RES_W'(-c[RES_W-1:0]);
      end else begin
        c = (r > POS_MAX) ? POS_MAX : r;
        sat_sign = c[RES_W-1:0];
      end
    end
  endfunction

  logic [FW-1:0] full1, full2;
  logic [RW-1:0] r1, r2;

  always_comb begin
    full1 = FW'({ph1, 16'h0000}) + FW'(pl1);
    full2 = FW'({ph2, 16'h0000}) + FW'(pl2);
    // central first derivative carries the extra halving
    if (central_s2) begin
      r1 = RW'(full1[FW-1:17]) + RW'(full1[16]);
    end else begin
      r1 = RW'(full1[FW-1:16]) + RW'(full1[15]);
    end
    r2 = RW'(full2[FW-1:16]) + RW'(full2[15]);
    first_d  = sat_sign(r1, neg1_s2);
    second_d = central_s2 ? sat_sign(r2, neg2_s2) : '0;
  end

endmodule

`default_nettype wire

// File: rtl/core/three_point_space_derivative.sv
// Top level of the three-point space derivative block: lanes and merge stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one voxel stencil per
//   transaction: axis, neighbour flags and the prev/cur/next samples of the
//   three components. Output channel (out_valid/out_ready) returns the first
//   and second derivative of each component, one result per input.
//   Three lanes, one per component, run side by side; the output register
//   merges their results into one transaction.
//   An accepted transaction passes stage 1, stage 2 and the output register,
//   which raises out_valid. Throughput is one transaction per cycle when not
//   stalled, set by the three-stage lane pipeline (difference, split 16-bit
//   multiply, round/saturate) which takes a new stencil each cycle.
//   A stalled receiver holds the output register; stages behind it keep
//   filling empty slots, so in_ready drops only when every stage is full.
//   Reset (rst, synchronous) empties the pipeline and loads every reciprocal
//   register with 1.0. The user must write reciprocals (cfg_wen, cfg_index,
//   cfg_data) only while no transaction is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module three_point_space_derivative
  import tpsd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic        [IDX_W-1:0]        cfg_index,
  input  wire logic        [CFG_W-1:0]        cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic        [1:0]              axis,
  input  wire logic                           prev_valid,
  input  wire logic                           next_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prev_a,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prev_b,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prev_c,
  input  wire logic signed [SAMPLE_WIDTH-1:0] cur_a,
  input  wire logic signed [SAMPLE_WIDTH-1:0] cur_b,
  input  wire logic signed [SAMPLE_WIDTH-1:0] cur_c,
  input  wire logic signed [SAMPLE_WIDTH-1:0] next_a,
  input  wire logic signed [SAMPLE_WIDTH-1:0] next_b,
  input  wire logic signed [SAMPLE_WIDTH-1:0] next_c,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed      [RES_W-1:0]        first_a,
  output logic signed      [RES_W-1:0]        first_b,
  output logic signed      [RES_W-1:0]        first_c,
  output logic signed      [RES_W-1:0]        second_a,
  output logic signed      [RES_W-1:0]        second_b,
  output logic signed      [RES_W-1:0]        second_c
);

  // Register file and axis selection
  logic [CFG_W-1:0] k1_sel, k2_sel;

  tpsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .axis      (axis),
    .k1        (k1_sel),
    .k2        (k2_sel)
  );

  // Stage occupancy and load enables; each stage fills when its slot frees
  logic       v1, v2;
  logic       en1, en2, en_out;
  tpsd_ctrl_t ctrl;

  always_comb begin
    en_out       = !out_valid || out_ready;
    en2          = !v2 || en_out;
    en1          = !v1 || en2;
    in_ready     = en1;
    ctrl.s1_load = en1;
    ctrl.s2_load = en2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en_out) begin
        out_valid <= v2;
      end
    end
  end

  // Hold the selected reciprocals next to the stage-1 samples
  logic [CFG_W-1:0] k1, k2;

  always_ff @(posedge clk) begin
    if (en1) begin
      k1 <= k1_sel;
      k2 <= k2_sel;
    end
  end

  // Component lanes
  logic signed [RES_W-1:0] lane_first  [3];
  logic signed [RES_W-1:0] lane_second [3];

  tpsd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_a (
    .clk        (clk),
    .ctrl       (ctrl),
    .prev_valid (prev_valid),
    .next_valid (next_valid),
    .prev_s     (prev_a),
    .cur_s      (cur_a),
    .next_s     (next_a),
    .k1         (k1),
    .k2         (k2),
    .first_d    (lane_first[0]),
    .second_d   (lane_second[0])
  );

  tpsd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_b (
    .clk        (clk),
    .ctrl       (ctrl),
    .prev_valid (prev_valid),
    .next_valid (next_valid),
    .prev_s     (prev_b),
    .cur_s      (cur_b),
    .next_s     (next_b),
    .k1         (k1),
    .k2         (k2),
    .first_d    (lane_first[1]),
    .second_d   (lane_second[1])
  );

  tpsd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_c (
    .clk        (clk),
    .ctrl       (ctrl),
    .prev_valid (prev_valid),
    .next_valid (next_valid),
    .prev_s     (prev_c),
    .cur_s      (cur_c),
    .next_s     (next_c),
    .k1         (k1),
    .k2         (k2),
    .first_d    (lane_first[2]),
    .second_d   (lane_second[2])
  );

  // Merge lane results into the output register; hold while stalled
  always_ff @(posedge clk) begin
    if (en_out) begin
      first_a  <= lane_first[0];
      first_b  <= lane_first[1];
      first_c  <= lane_first[2];
      second_a <= lane_second[0];
      second_b <= lane_second[1];
      second_c <= lane_second[2];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tpsd_checker.sv
// Port-level checks for the three-point space derivative block, with bind.
`timescale 1ns / 1ps
`default_nettype none

module tpsd_checker
  import tpsd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [RES_W-1:0] first_a,
  input wire logic signed [RES_W-1:0] second_a
);

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_a) && $stable(second_a))
    else $error("stalled result changed");

  // Backpressure only when the receiver stalls a waiting result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // An accepted transaction reaches out_valid through stages 1 and 2 when not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind three_point_space_derivative tpsd_checker u_tpsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .first_a   (first_a),
  .second_a  (second_a)
);

`default_nettype wire
